// ----- hw/rtl/aalw_pkg.sv -----
// Package for the accelerometer activity level window block.
// Holds field widths, register codes, level codes and the config struct.
// No dependencies.
`timescale 1ns / 1ps

package aalw_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int DEV_W          = 32;
    localparam int SCORE_W        = 16;
    localparam int LEVEL_W        = 3;
    localparam int COUNT_W        = 8;
    localparam int PHASE_W        = 4;
    localparam int CFG_INDEX_W    = 3;
    localparam int CFG_DATA_W     = 16;
    localparam int ONE_G_SQ_SHIFT = 28;
    localparam int SCORE_SCALE    = 400;

    // largest |x^2+y^2+z^2 - 2^28| for full-scale inputs
    localparam logic [DEV_W-1:0] MAX_DEV = 32'hB000_0000;

    localparam logic [COUNT_W-1:0] COUNT_LAST = 8'hFF;
    localparam logic [PHASE_W-1:0] PHASE_LAST = 4'd9;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SCORE_CEILING = 3'd0,
        CFG_STILL_LIMIT   = 3'd1,
        CFG_SLIGHT_LIMIT  = 3'd2,
        CFG_WALK_LIMIT    = 3'd3,
        CFG_RUN_LIMIT     = 3'd4
    } cfg_index_t;

    typedef enum logic [LEVEL_W-1:0] {
        LEVEL_STILL    = 3'd0,
        LEVEL_SLIGHT   = 3'd1,
        LEVEL_WALK     = 3'd2,
        LEVEL_RUN      = 3'd3,
        LEVEL_VIGOROUS = 3'd4
    } level_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] score_ceiling;
        logic [CFG_DATA_W-1:0] still_limit;
        logic [CFG_DATA_W-1:0] slight_limit;
        logic [CFG_DATA_W-1:0] walk_limit;
        logic [CFG_DATA_W-1:0] run_limit;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        score_ceiling: 16'd1000,
        still_limit:   16'd40,
        slight_limit:  16'd120,
        walk_limit:    16'd300,
        run_limit:     16'd550
    };

endpackage

// ----- hw/rtl/aalw_cell.sv -----
// One cell of the deviation window shift line.
// Holds one deviation value and passes it on to the next cell on each shift.
// Depends on aalw_pkg.
`timescale 1ns / 1ps

module aalw_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       shift,
    input  logic [aalw_pkg::DEV_W-1:0] din,
    output logic [aalw_pkg::DEV_W-1:0] dout
);

    logic [aalw_pkg::DEV_W-1:0] data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else if (shift)
        begin
            data_reg <= din;
        end
    end

    assign dout = data_reg;

endmodule

// ----- hw/rtl/aalw_dev.sv -----
// Deviation datapath: squares of the three axes, then |sum - 1 g^2|.
// Two register stages, loaded by enables from the top level.
// Depends on aalw_pkg.
`timescale 1ns / 1ps

module aalw_dev (
    input  logic                                 clk,
    input  logic                                 load_sq,
    input  logic                                 load_dev,
    input  logic signed [aalw_pkg::SAMPLE_W-1:0] accel_x,
    input  logic signed [aalw_pkg::SAMPLE_W-1:0] accel_y,
    input  logic signed [aalw_pkg::SAMPLE_W-1:0] accel_z,
    output logic        [aalw_pkg::DEV_W-1:0]    dev
);

    localparam int SQ_W  = 2 * aalw_pkg::SAMPLE_W;
    localparam int SUM_W = SQ_W + 2;
    localparam logic [SUM_W-1:0] ONE_G_SQ = SUM_W'(1) << aalw_pkg::ONE_G_SQ_SHIFT;

    logic signed [SQ_W-1:0] sq_x_next;
    logic signed [SQ_W-1:0] sq_y_next;
    logic signed [SQ_W-1:0] sq_z_next;
    logic        [SQ_W-1:0] sq_x_reg;
    logic        [SQ_W-1:0] sq_y_reg;
    logic        [SQ_W-1:0] sq_z_reg;
    logic        [SUM_W-1:0] mag;
    logic        [SUM_W-1:0] above;
    logic        [SUM_W-1:0] below;
    logic        [aalw_pkg::DEV_W-1:0] dev_next;
    logic        [aalw_pkg::DEV_W-1:0] dev_reg;

    assign sq_x_next = SQ_W'(accel_x) * SQ_W'(accel_x);
    assign sq_y_next = SQ_W'(accel_y) * SQ_W'(accel_y);
    assign sq_z_next = SQ_W'(accel_z) * SQ_W'(accel_z);

    always_ff @(posedge clk)
    begin
        if (load_sq)
        begin
            sq_x_reg <= unsigned'(sq_x_next);
            sq_y_reg <= unsigned'(sq_y_next);
            sq_z_reg <= unsigned'(sq_z_next);
        end
    end

    always_comb
    begin
        mag   = SUM_W'(sq_x_reg) + SUM_W'(sq_y_reg) + SUM_W'(sq_z_reg);
        above = mag - ONE_G_SQ;
        below = ONE_G_SQ - mag;
        if (mag >= ONE_G_SQ)
        begin
            dev_next = above[aalw_pkg::DEV_W-1:0];
        end
        else
        begin
            dev_next = below[aalw_pkg::DEV_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_dev)
        begin
            dev_reg <= dev_next;
        end
    end

    assign dev = dev_reg;

endmodule

// ----- hw/rtl/aalw_score.sv -----
// Score datapath: total * 400 / 2^28, divide by the window length through a
// reciprocal multiply, then clamp and classify. Three register stages.
// Depends on aalw_pkg.
`timescale 1ns / 1ps

module aalw_score #(
    parameter int WINDOW_LENGTH = 50
) (
    input  logic                                     clk,
    input  logic                                     load_scale,
    input  logic                                     load_recip,
    input  logic                                     load_out,
    input  logic [$clog2(longint'(WINDOW_LENGTH) * longint'(aalw_pkg::MAX_DEV) + 1)-1:0] total,
    input  aalw_pkg::cfg_t                           cfg,
    output logic [aalw_pkg::SCORE_W-1:0]             motion_score,
    output logic [aalw_pkg::LEVEL_W-1:0]             activity_level
);

    localparam longint MAX_TOTAL = longint'(WINDOW_LENGTH) * longint'(aalw_pkg::MAX_DEV);
    localparam int TOTAL_W   = $clog2(MAX_TOTAL + 1);
    localparam int SCALED_W  = TOTAL_W + $clog2(aalw_pkg::SCORE_SCALE);
    localparam int Y_W       = SCALED_W - aalw_pkg::ONE_G_SQ_SHIFT;
    localparam int K         = Y_W + $clog2(WINDOW_LENGTH);
    localparam longint RECIP_VAL = ((longint'(1) << K) + longint'(WINDOW_LENGTH) - 1)
                                   / longint'(WINDOW_LENGTH);
    localparam int RECIP_W   = $clog2(RECIP_VAL + 1);
    localparam int PROD_W    = Y_W + RECIP_W;
    localparam int RAW_W     = PROD_W - K;
    localparam int CMP_W     = (RAW_W > aalw_pkg::SCORE_W) ? RAW_W : aalw_pkg::SCORE_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);

    logic [SCALED_W-1:0]          scaled;
    logic [Y_W-1:0]               y_reg;
    logic [PROD_W-1:0]            prod_next;
    logic [PROD_W-1:0]            prod_reg;
    logic [RAW_W-1:0]             raw;
    logic [CMP_W-1:0]             raw_ext;
    logic [aalw_pkg::SCORE_W-1:0] score_next;
    aalw_pkg::level_t             level_next;
    logic [aalw_pkg::SCORE_W-1:0] score_reg;
    aalw_pkg::level_t             level_reg;

    assign scaled = SCALED_W'(total) * SCALED_W'(aalw_pkg::SCORE_SCALE);

    always_ff @(posedge clk)
    begin
        if (load_scale)
        begin
            y_reg <= scaled[SCALED_W-1:aalw_pkg::ONE_G_SQ_SHIFT];
        end
    end

    // floor(y * RECIP / 2^K) equals floor(y / WINDOW_LENGTH) for every y below 2^Y_W
    assign prod_next = PROD_W'(y_reg) * PROD_W'(RECIP);

    always_ff @(posedge clk)
    begin
        if (load_recip)
        begin
            prod_reg <= prod_next;
        end
    end

    always_comb
    begin
        raw     = prod_reg[PROD_W-1:K];
        raw_ext = CMP_W'(raw);
        if (raw_ext > CMP_W'(cfg.score_ceiling))
        begin
            score_next = cfg.score_ceiling;
        end
        else
        begin
            score_next = raw_ext[aalw_pkg::SCORE_W-1:0];
        end
        priority if (score_next < cfg.still_limit)
        begin
            level_next = aalw_pkg::LEVEL_STILL;
        end
        else if (score_next < cfg.slight_limit)
        begin
            level_next = aalw_pkg::LEVEL_SLIGHT;
        end
        else if (score_next < cfg.walk_limit)
        begin
            level_next = aalw_pkg::LEVEL_WALK;
        end
        else if (score_next < cfg.run_limit)
        begin
            level_next = aalw_pkg::LEVEL_RUN;
        end
        else
        begin
            level_next = aalw_pkg::LEVEL_VIGOROUS;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            score_reg <= score_next;
            level_reg <= level_next;
        end
    end

    assign motion_score   = score_reg;
    assign activity_level = level_reg;

endmodule

// ----- hw/rtl/accel_activity_level_window.sv -----
// Activity level from accelerometer samples over a sliding window of deviations.
// A sample beat passes the sq, dev, tot, scl, rcp and out stages; every tenth gives a result beat.
// Throughput: one sample per cycle while sample_stall is low; the window is a shift line of cells
// that moves once per sample, and the running total is updated in the same cycle.
// Reset: window cells, total, counters and pipeline valids clear; registers take defaults.
// Depends on aalw_pkg, aalw_cell, aalw_dev, aalw_score.
`timescale 1ns / 1ps

module accel_activity_level_window #(
    parameter int WINDOW_LENGTH = 50
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    sample_valid,
    output logic                                    sample_stall,
    input  logic signed [aalw_pkg::SAMPLE_W-1:0]    accel_x,
    input  logic signed [aalw_pkg::SAMPLE_W-1:0]    accel_y,
    input  logic signed [aalw_pkg::SAMPLE_W-1:0]    accel_z,
    output logic                                    result_valid,
    input  logic                                    result_stall,
    output logic        [aalw_pkg::SCORE_W-1:0]     motion_score,
    output logic        [aalw_pkg::LEVEL_W-1:0]     activity_level,
    output logic        [aalw_pkg::COUNT_W-1:0]     sample_number,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic        [aalw_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic        [aalw_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam longint MAX_TOTAL = longint'(WINDOW_LENGTH) * longint'(aalw_pkg::MAX_DEV);
    localparam int TOTAL_W = $clog2(MAX_TOTAL + 1);

    aalw_pkg::cfg_t cfg_reg;

    logic [aalw_pkg::COUNT_W-1:0] cnt_reg;
    logic [aalw_pkg::PHASE_W-1:0] phase_reg;

    logic sq_v_reg, dev_v_reg, tot_v_reg, scl_v_reg, rcp_v_reg, out_v_reg;
    logic sq_emit_reg, dev_emit_reg;
    logic [aalw_pkg::COUNT_W-1:0] sq_cnt_reg, dev_cnt_reg, tot_cnt_reg;
    logic [aalw_pkg::COUNT_W-1:0] scl_cnt_reg, rcp_cnt_reg, out_cnt_reg;

    logic sq_rdy, dev_rdy, tot_rdy, scl_rdy, rcp_rdy, out_rdy;
    logic accept;
    logic commit;

    logic [aalw_pkg::DEV_W-1:0] dev;
    logic [aalw_pkg::DEV_W-1:0] cell_out [WINDOW_LENGTH];
    logic [TOTAL_W-1:0]         total_reg;
    logic [TOTAL_W-1:0]         total_next;
    logic [TOTAL_W-1:0]         snap_reg;

    // ready chain, back to front
    assign out_rdy = !out_v_reg || !result_stall;
    assign rcp_rdy = !rcp_v_reg || out_rdy;
    assign scl_rdy = !scl_v_reg || rcp_rdy;
    assign tot_rdy = !tot_v_reg || scl_rdy;
    assign dev_rdy = !dev_v_reg || tot_rdy;
    assign sq_rdy  = !sq_v_reg  || dev_rdy;

    assign sample_stall = !sq_rdy;
    assign accept       = sample_valid && sq_rdy;
    assign commit       = dev_v_reg && tot_rdy;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= aalw_pkg::CFG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                aalw_pkg::CFG_SCORE_CEILING: cfg_reg.score_ceiling <= cfg_data;
                aalw_pkg::CFG_STILL_LIMIT:   cfg_reg.still_limit   <= cfg_data;
                aalw_pkg::CFG_SLIGHT_LIMIT:  cfg_reg.slight_limit  <= cfg_data;
                aalw_pkg::CFG_WALK_LIMIT:    cfg_reg.walk_limit    <= cfg_data;
                aalw_pkg::CFG_RUN_LIMIT:     cfg_reg.run_limit     <= cfg_data;
                default: ;
            endcase
        end
    end

    // phase tracks cnt mod 10, restarting where the 8-bit count wraps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            phase_reg <= '0;
        end
        else if (accept)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == aalw_pkg::COUNT_LAST || phase_reg == aalw_pkg::PHASE_LAST)
            begin
                phase_reg <= '0;
            end
            else
            begin
                phase_reg <= phase_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_v_reg  <= 1'b0;
            dev_v_reg <= 1'b0;
            tot_v_reg <= 1'b0;
            scl_v_reg <= 1'b0;
            rcp_v_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (sq_rdy)
            begin
                sq_v_reg <= sample_valid;
            end
            if (dev_rdy)
            begin
                dev_v_reg <= sq_v_reg;
            end
            if (tot_rdy)
            begin
                tot_v_reg <= dev_v_reg && dev_emit_reg;
            end
            if (scl_rdy)
            begin
                scl_v_reg <= tot_v_reg;
            end
            if (rcp_rdy)
            begin
                rcp_v_reg <= scl_v_reg;
            end
            if (out_rdy)
            begin
                out_v_reg <= rcp_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sq_rdy)
        begin
            sq_cnt_reg  <= cnt_reg;
            sq_emit_reg <= (phase_reg == '0);
        end
        if (dev_rdy)
        begin
            dev_cnt_reg  <= sq_cnt_reg;
            dev_emit_reg <= sq_emit_reg;
        end
        if (tot_rdy)
        begin
            tot_cnt_reg <= dev_cnt_reg;
            snap_reg    <= total_next;
        end
        if (scl_rdy)
        begin
            scl_cnt_reg <= tot_cnt_reg;
        end
        if (rcp_rdy)
        begin
            rcp_cnt_reg <= scl_cnt_reg;
        end
        if (out_rdy)
        begin
            out_cnt_reg <= rcp_cnt_reg;
        end
    end

    aalw_dev u_dev (
        .clk      (clk),
        .load_sq  (sq_rdy),
        .load_dev (dev_rdy),
        .accel_x  (accel_x),
        .accel_y  (accel_y),
        .accel_z  (accel_z),
        .dev      (dev)
    );

    // window shift line: newest at cell 0, oldest leaves from the last cell
    for (genvar i = 0; i < WINDOW_LENGTH; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            aalw_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (commit),
                .din   (dev),
                .dout  (cell_out[i])
            );
        end
        else
        begin : g_link
            aalw_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (commit),
                .din   (cell_out[i-1]),
                .dout  (cell_out[i])
            );
        end
    end

    always_comb
    begin
        if (commit)
        begin
            total_next = total_reg - TOTAL_W'(cell_out[WINDOW_LENGTH-1]) + TOTAL_W'(dev);
        end
        else
        begin
            total_next = total_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
        end
        else
        begin
            total_reg <= total_next;
        end
    end

    aalw_score #(
        .WINDOW_LENGTH (WINDOW_LENGTH)
    ) u_score (
        .clk            (clk),
        .load_scale     (scl_rdy),
        .load_recip     (rcp_rdy),
        .load_out       (out_rdy),
        .total          (snap_reg),
        .cfg            (cfg_reg),
        .motion_score   (motion_score),
        .activity_level (activity_level)
    );

    assign result_valid  = out_v_reg;
    assign sample_number = out_cnt_reg;

    a_phase_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> (phase_reg == '0))
        else $error("phase out of step with sample count");

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= aalw_pkg::PHASE_LAST)
        else $error("phase beyond emit period");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> sq_v_reg)
        else $error("input stalled with empty first stage");

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= TOTAL_W'(MAX_TOTAL))
        else $error("window total out of range");

endmodule

// ----- sim/aalw_activity_checker.sv -----
`timescale 1ns / 1ps
// Checker for accel_activity_level_window: follows the sample, result and register channels.
// Predicts score, level and sample number for every tenth sample beat and compares the result beats.
// Depends on aalw_pkg.

module aalw_activity_checker
    import aalw_pkg::*;
#(
    parameter int WINDOW_LENGTH = 50
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   sample_valid,
    input  logic                   sample_stall,
    input  logic [SAMPLE_W-1:0]    accel_x,
    input  logic [SAMPLE_W-1:0]    accel_y,
    input  logic [SAMPLE_W-1:0]    accel_z,
    input  logic                   result_valid,
    input  logic                   result_stall,
    input  logic [SCORE_W-1:0]     motion_score,
    input  logic [LEVEL_W-1:0]     activity_level,
    input  logic [COUNT_W-1:0]     sample_number,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     mismatch_count,
    output int                     pending_results
);

    localparam int EMIT_PERIOD = 10;

    typedef struct {
        logic [SCORE_W-1:0] score;
        level_t             level;
        logic [COUNT_W-1:0] number;
    } activity_t;

    activity_t          expected_activity[$];
    logic [DEV_W-1:0]   window_dev[WINDOW_LENGTH];
    logic [37:0]        window_sum;
    int                 slot;
    logic [COUNT_W-1:0] samples_seen;
    cfg_t               regs;

    function automatic logic [DEV_W-1:0] gravity_deviation(logic signed [SAMPLE_W-1:0] x,
                                                           logic signed [SAMPLE_W-1:0] y,
                                                           logic signed [SAMPLE_W-1:0] z);
        longint sq;
        sq = longint'(x) * longint'(x) + longint'(y) * longint'(y) + longint'(z) * longint'(z);
        sq = sq - (longint'(1) << ONE_G_SQ_SHIFT);
        return (sq < 0) ? DEV_W'(-sq) : DEV_W'(sq);
    endfunction

    function automatic level_t classify_score(logic [SCORE_W-1:0] s, cfg_t c);
        if (s < c.still_limit)  return LEVEL_STILL;
        if (s < c.slight_limit) return LEVEL_SLIGHT;
        if (s < c.walk_limit)   return LEVEL_WALK;
        if (s < c.run_limit)    return LEVEL_RUN;
        return LEVEL_VIGOROUS;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [DEV_W-1:0] dev;
        logic [63:0]      raw;
        activity_t        want;
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW_LENGTH; i++) window_dev[i] = '0;
            window_sum = '0;
            slot = 0;
            samples_seen = '0;
            regs = CFG_RESET;
            expected_activity.delete();
            mismatch_count = 0;
            pending_results = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SCORE_CEILING: regs.score_ceiling = cfg_data;
                    CFG_STILL_LIMIT:   regs.still_limit = cfg_data;
                    CFG_SLIGHT_LIMIT:  regs.slight_limit = cfg_data;
                    CFG_WALK_LIMIT:    regs.walk_limit = cfg_data;
                    CFG_RUN_LIMIT:     regs.run_limit = cfg_data;
                    default: ;
                endcase
            end

            if (sample_valid && !sample_stall)
            begin
                dev = gravity_deviation(accel_x, accel_y, accel_z);
                window_sum = window_sum - window_dev[slot] + dev;
                window_dev[slot] = dev;
                slot = (slot == WINDOW_LENGTH - 1) ? 0 : slot + 1;
                if (samples_seen % EMIT_PERIOD == 0)
                begin
                    raw = (64'(window_sum) * 64'(SCORE_SCALE)) /
                          (64'(WINDOW_LENGTH) << ONE_G_SQ_SHIFT);
                    if (raw > 64'(regs.score_ceiling)) raw = 64'(regs.score_ceiling);
                    want.score = SCORE_W'(raw);
                    want.level = classify_score(want.score, regs);
                    want.number = samples_seen;
                    expected_activity.push_back(want);
                end
                samples_seen = samples_seen + 1'b1;
            end

            if (result_valid && !result_stall)
            begin
                if (expected_activity.size() == 0)
                begin
                    $error("result beat with no result expected: score %0d level %0d number %0d",
                           motion_score, activity_level, sample_number);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_activity.pop_front();
                    if (motion_score !== want.score)
                    begin
                        $error("motion_score expected %0d actual %0d", want.score, motion_score);
                        mismatch_count++;
                    end
                    if (activity_level !== want.level)
                    begin
                        $error("activity_level expected %0d actual %0d",
                               want.level, activity_level);
                        mismatch_count++;
                    end
                    if (sample_number !== want.number)
                    begin
                        $error("sample_number expected %0d actual %0d",
                               want.number, sample_number);
                        mismatch_count++;
                    end
                end
            end
            pending_results = expected_activity.size();
        end
    end

endmodule

// ----- sim/accel_activity_level_window_tb.sv -----
`timescale 1ns / 1ps
// Top of the accel_activity_level_window testbench: clock, reset, sample and register stimulus.
// Instantiates the block and aalw_activity_checker; depends on aalw_pkg.

module accel_activity_level_window_tb;

    import aalw_pkg::*;

    localparam int WINDOW       = 50;
    localparam int MAX_GAP      = 18;
    localparam int SETTLE       = 12;
    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_BEATS = 42;
    localparam int NUM_PHASES   = 9;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                       sample_valid = 1'b0;
    logic                       sample_stall;
    logic signed [SAMPLE_W-1:0] accel_x = '0;
    logic signed [SAMPLE_W-1:0] accel_y = '0;
    logic signed [SAMPLE_W-1:0] accel_z = '0;
    logic                       result_valid;
    logic                       result_stall = 1'b0;
    logic [SCORE_W-1:0]         motion_score;
    logic [LEVEL_W-1:0]         activity_level;
    logic [COUNT_W-1:0]         sample_number;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_INDEX_W-1:0]     cfg_index = '0;
    logic [CFG_DATA_W-1:0]      cfg_data = '0;

    int   mismatch_count;
    int   pending_results;
    logic quiet_phase = 1'b0;
    logic took_result = 1'b0;
    int   result_gap = 0;
    int   idle_cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    accel_activity_level_window #(
        .WINDOW_LENGTH(WINDOW)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .sample_valid  (sample_valid),
        .sample_stall  (sample_stall),
        .accel_x       (accel_x),
        .accel_y       (accel_y),
        .accel_z       (accel_z),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .motion_score  (motion_score),
        .activity_level(activity_level),
        .sample_number (sample_number),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    aalw_activity_checker #(
        .WINDOW_LENGTH(WINDOW)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample_valid   (sample_valid),
        .sample_stall   (sample_stall),
        .accel_x        (accel_x),
        .accel_y        (accel_y),
        .accel_z        (accel_z),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .motion_score   (motion_score),
        .activity_level (activity_level),
        .sample_number  (sample_number),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .pending_results(pending_results)
    );

    function automatic int draw_gap();
        if (quiet_phase || $urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] saturate(int v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return v[SAMPLE_W-1:0];
    endfunction

    // result side: after each result beat, hold stall for a freshly drawn number of cycles
    always @(posedge clk) took_result <= result_valid && !result_stall;

    always @(negedge clk)
    begin
        int n;
        n = took_result ? draw_gap() : result_gap;
        if (n != 0)
        begin
            result_stall <= 1'b1;
            result_gap <= n - 1;
        end
        else
        begin
            result_stall <= 1'b0;
            result_gap <= 0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((sample_valid && !sample_stall) || (result_valid && !result_stall) ||
                (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles == STALL_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // all tasks are entered and left at a falling edge
    task automatic send_sample(logic signed [SAMPLE_W-1:0] x, logic signed [SAMPLE_W-1:0] y,
                               logic signed [SAMPLE_W-1:0] z);
        int gap;
        gap = draw_gap();
        if (gap != 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_valid <= 1'b1;
        accel_x <= x;
        accel_y <= y;
        accel_z <= z;
        do @(posedge clk); while (sample_stall);
        @(negedge clk);
    endtask

    task automatic send_motion(int amp);
        int g[3];
        int axis;
        if ($urandom_range(0, 9) == 0)
        begin
            send_sample(SAMPLE_W'($urandom), SAMPLE_W'($urandom), SAMPLE_W'($urandom));
        end
        else
        begin
            axis = $urandom_range(0, 2);
            for (int i = 0; i < 3; i++)
            begin
                g[i] = (i == axis) ? ($urandom_range(0, 1) ? 16384 : -16384) : 0;
                g[i] = g[i] + int'($urandom_range(0, 2 * amp)) - amp;
            end
            send_sample(saturate(g[0]), saturate(g[1]), saturate(g[2]));
        end
    endtask

    task automatic drain();
        sample_valid <= 1'b0;
        while (pending_results != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // leaves cfg_valid high so that writes can follow back to back; the caller drops it
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic set_limits(logic [CFG_DATA_W-1:0] ceiling, logic [CFG_DATA_W-1:0] still,
                              logic [CFG_DATA_W-1:0] slight, logic [CFG_DATA_W-1:0] walk,
                              logic [CFG_DATA_W-1:0] run);
        write_reg(CFG_SCORE_CEILING, ceiling);
        write_reg(CFG_STILL_LIMIT, still);
        write_reg(CFG_SLIGHT_LIMIT, slight);
        write_reg(CFG_WALK_LIMIT, walk);
        write_reg(CFG_RUN_LIMIT, run);
    endtask

    initial
    begin
        int amp;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // corners: zero, full scale both signs, exactly 1 g on each axis, alternating bits
        send_sample(16'sh0000, 16'sh0000, 16'sh0000);
        send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_sample(16'sh8000, 16'sh8000, 16'sh8000);
        send_sample(16'sh7FFF, 16'sh8000, 16'sh7FFF);
        send_sample(16'sh4000, 16'sh0000, 16'sh0000);
        send_sample(16'sh0000, 16'shC000, 16'sh0000);
        send_sample(16'sh0000, 16'sh0000, 16'sh4000);
        send_sample(16'shC000, 16'sh0000, 16'sh0000);
        send_sample(16'sh5555, 16'shAAAA, 16'sh5555);
        send_sample(16'shAAAA, 16'sh5555, 16'shAAAA);
        send_sample(16'sh8000, 16'sh0000, 16'sh0000);
        send_sample(16'sh0001, 16'shFFFF, 16'sh0001);
        send_sample(16'sh0000, 16'sh8000, 16'sh0000);
        send_sample(16'sh0000, 16'sh0000, 16'sh7FFF);
        send_sample(16'sh3FFF, 16'sh0000, 16'sh0000);
        send_sample(16'sh0000, 16'sh0000, 16'sh4001);
        send_sample(16'sh8000, 16'sh7FFF, 16'sh8000);
        send_sample(16'sh2000, 16'sh2000, 16'sh2000);
        send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_sample(16'sh8000, 16'sh8000, 16'sh8000);
        send_sample(16'sh7FFF, 16'sh8000, 16'sh0000);
        send_sample(16'sh0000, 16'sh0000, 16'sh4000);
        drain();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: set_limits(16'hFFFF, 16'd40, 16'd120, 16'd300, 16'd550);
                1: set_limits(16'h0000, 16'd40, 16'd120, 16'd300, 16'd550);
                2: set_limits(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
                3: set_limits(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                4: set_limits(16'd3000, 16'd500, 16'd100, 16'd2000, 16'd50);
                5: set_limits(16'd200, 16'd40, 16'd120, 16'd300, 16'd550);
                6:
                begin
                    set_limits(CFG_RESET.score_ceiling, CFG_RESET.still_limit,
                               CFG_RESET.slight_limit, CFG_RESET.walk_limit,
                               CFG_RESET.run_limit);
                    // indexes past the register list must leave everything unchanged
                    for (int i = int'(CFG_RUN_LIMIT) + 1; i < (1 << CFG_INDEX_W); i++)
                        write_reg(CFG_INDEX_W'(i), CFG_DATA_W'($urandom));
                end
                default: set_limits(CFG_DATA_W'($urandom_range(300, 65535)),
                                    CFG_DATA_W'($urandom_range(0, 1500)),
                                    CFG_DATA_W'($urandom_range(0, 1500)),
                                    CFG_DATA_W'($urandom_range(0, 1500)),
                                    CFG_DATA_W'($urandom_range(0, 1500)));
            endcase
            cfg_valid <= 1'b0;
            quiet_phase = ($urandom_range(0, 3) == 0);
            amp = 0;
            for (int n = 0; n < RANDOM_BEATS; n++)
            begin
                if (n % 14 == 0 || $urandom_range(0, 14) == 0)
                    amp = $urandom_range(0, 1 << $urandom_range(0, 15));
                send_motion(amp);
            end
            drain();
        end

        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
